[sv/bvc_pkg.sv]
// bvc_pkg: shared constants, types and helpers for the battery voltage conditioner
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bvc_pkg;

    // sizes of the series and the history
    localparam int SERIES_SAMPLES = 8;
    localparam int HISTORY_DEPTH  = 16;

    // field and register widths
    localparam int SAMPLE_W  = 12;
    localparam int GAIN_W    = 18;
    localparam int DELTA_W   = 10;
    localparam int DISCARD_W = 8;
    localparam int MV_W      = 14;
    localparam int Q8_W      = 22;
    localparam int TREND_W   = 2;

    // register reset values
    localparam logic [GAIN_W-1:0]    GAIN_RESET    = GAIN_W'(131072);
    localparam logic [DELTA_W-1:0]   DELTA_RESET   = DELTA_W'(20);
    localparam logic [DISCARD_W-1:0] DISCARD_RESET = DISCARD_W'(2);

    // series accumulation
    localparam int CNT_W  = $clog2(SERIES_SAMPLES);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int PROD_W = SUM_W + GAIN_W;

    // trimmed mean divide: (prod + H) / (256 * DIV_C), done as >> 8 then a
    // reciprocal multiply by DIV_C, exact for every value below the saturation point
    localparam int DIV_C     = SERIES_SAMPLES - 2;
    localparam int DIV_CW    = $clog2(DIV_C);
    localparam int X_W       = Q8_W + DIV_CW;
    localparam int XS_W      = PROD_W - 7;
    localparam int RECIP_K   = X_W + DIV_CW;
    localparam int RECIP_M_W = X_W + 1;
    localparam logic [63:0] RECIP_M64 =
        ((64'd1 << RECIP_K) + 64'(DIV_C) - 64'd1) / 64'(DIV_C);
    localparam logic [RECIP_M_W-1:0] RECIP_M  = RECIP_M64[RECIP_M_W-1:0];
    localparam logic [PROD_W:0]      ROUND_H  = (PROD_W+1)'(DIV_C * 128);
    localparam logic [63:0]          X_LIM64  = 64'(DIV_C) << Q8_W;
    localparam logic [XS_W-1:0]      X_LIM    = X_LIM64[XS_W-1:0];

    // filter: (9 * f + inst + 5) / 10 through a reciprocal multiply
    localparam int Y_W      = Q8_W + 4;
    localparam int TEN_K    = Y_W + 4;
    localparam int TEN_M_W  = Y_W + 1;
    localparam logic [63:0] TEN_M64 = ((64'd1 << TEN_K) + 64'd9) / 64'd10;
    localparam logic [TEN_M_W-1:0] TEN_M = TEN_M64[TEN_M_W-1:0];

    localparam logic [Q8_W-1:0] Q8_MAX        = '1;
    localparam logic [Q8_W-1:0] SEED_LIMIT_Q8 = Q8_W'(25600);

    // history ring
    localparam int HIST_AW = $clog2(HISTORY_DEPTH);
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);

    // port widths
    localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int RES_W      = 2 * MV_W + TREND_W;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLTAGE_GAIN  = 2'd0,
        CFG_TREND_DELTA   = 2'd1,
        CFG_DISCARD_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [TREND_W-1:0] {
        TREND_UNKNOWN     = 2'd0,
        TREND_CHARGING    = 2'd1,
        TREND_DISCHARGING = 2'd2,
        TREND_STABLE      = 2'd3
    } t_trend;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] trim;
    } t_scale_in;

    typedef struct packed {
        logic            valid;
        logic [Q8_W-1:0] inst_q8;
        logic [Q8_W-1:0] filt_q8;
    } t_scale_out;

    typedef struct packed {
        t_trend          trend;
        logic [MV_W-1:0] filt_mv;
        logic [MV_W-1:0] inst_mv;
    } t_result;

    // q8 millivolts to integer millivolts, round half up, saturated
    function automatic logic [MV_W-1:0] q8_to_mv(input logic [Q8_W-1:0] q);
        logic [Q8_W:0] r;
        r = {1'b0, q} + (Q8_W+1)'(128);
        return (|r[Q8_W:8+MV_W]) ? {MV_W{1'b1}} : r[8+MV_W-1:8];
    endfunction

endpackage

`default_nettype wire

[sv/bvc_scale.sv]
// bvc_scale: gain, trimmed mean divide and exponential filter pipeline
// depends on bvc_pkg; holds the filter state
`timescale 1ns / 1ps
`default_nettype none

module bvc_scale (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [bvc_pkg::GAIN_W-1:0] i_gain,
    input  wire bvc_pkg::t_scale_in        i_in,
    output bvc_pkg::t_scale_out            o_out
);
    import bvc_pkg::*;

    // stage a: gain product
    logic                  r_va;
    logic [PROD_W-1:0]     r_prod;
    // stage b: rounding offset, drop 8 bits, saturation test
    logic                  r_vb;
    logic [X_W-1:0]        r_x;
    logic                  r_sat;
    // stage c: reciprocal multiply
    logic                  r_vc;
    logic [Q8_W-1:0]       r_inst_c;
    // stage d: filter numerator
    logic                  r_vd;
    logic [Y_W-1:0]        r_y;
    logic                  r_seed;
    logic [Q8_W-1:0]       r_inst_d;
    // stage e: divide by ten, filter update
    logic                  r_ve;
    logic [Q8_W-1:0]       r_inst_e;
    logic [Q8_W-1:0]       r_f;

    logic [PROD_W:0]             num;
    logic [XS_W-1:0]             xs;
    logic [X_W+RECIP_M_W-1:0]    prod_c;
    logic [Q8_W-1:0]             n_inst_c;
    logic [Y_W+TEN_M_W-1:0]      prod_e;
    logic [Q8_W:0]               q_e;
    logic [Q8_W-1:0]             n_f;

    always_comb begin
        num      = {1'b0, r_prod} + ROUND_H;
        xs       = num[PROD_W:8];
        prod_c   = r_x * RECIP_M;
        n_inst_c = r_sat ? Q8_MAX : prod_c[RECIP_K+Q8_W-1:RECIP_K];
        prod_e   = r_y * TEN_M;
        q_e      = prod_e[TEN_K+Q8_W:TEN_K];
        if (r_seed) begin
            n_f = r_inst_d;
        end else if (q_e[Q8_W]) begin
            n_f = Q8_MAX;
        end else begin
            n_f = q_e[Q8_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_f  <= '0;
        end else begin
            r_va <= i_in.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            if (r_vd) begin
                r_f <= n_f;
            end
        end
        r_prod   <= PROD_W'(i_in.trim) * PROD_W'(i_gain);
        r_sat    <= (xs >= X_LIM);
        r_x      <= xs[X_W-1:0];
        r_inst_c <= n_inst_c;
        // reads the filter state that the previous series left
        r_y      <= Y_W'({r_f, 3'b000}) + Y_W'(r_f) + Y_W'(r_inst_c) + Y_W'(5);
        r_seed   <= (r_f < SEED_LIMIT_Q8);
        r_inst_d <= r_inst_c;
        r_inst_e <= r_inst_d;
    end

    assign o_out.valid   = r_ve;
    assign o_out.inst_q8 = r_inst_e;
    assign o_out.filt_q8 = r_f;

endmodule

`default_nettype wire

[sv/battery_voltage_conditioner_core.sv]
// battery_voltage_conditioner_core: top level of the battery voltage conditioner
// depends on bvc_pkg and bvc_scale
//
// throughput: one sample word per cycle; a result is produced per completed series
// a result passes the scale handoff, scale stages a to e and the millivolt stage into the buffer
// the 2-entry result buffer stalls only the closing sample while two results are pending
// reset: synchronous, active low; config registers return to their defaults,
// series and filter state clear, the history ring keeps its contents but is unread until refilled
`timescale 1ns / 1ps
`default_nettype none

module battery_voltage_conditioner_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // sample stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [11:0] sample_mv
    input  wire logic [bvc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [13:0] instant_mv, [27:14] filtered_mv, [29:28] trend_code
    output logic [bvc_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    // configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic [bvc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bvc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bvc_pkg::*;

    // configuration registers
    logic [GAIN_W-1:0]    r_gain;
    logic [DELTA_W-1:0]   r_delta;
    logic [DISCARD_W-1:0] r_discard_cnt;

    // series state
    logic [DISCARD_W-1:0] r_discard_left;
    logic [CNT_W-1:0]     r_count;
    logic [SUM_W-1:0]     r_sum;
    logic [SAMPLE_W-1:0]  r_min;
    logic [SAMPLE_W-1:0]  r_max;

    // handoff to the scale pipeline
    t_scale_in            r_scale_in;
    t_scale_out           scale_out;

    // millivolt stage
    logic                 r_v6;
    logic [MV_W-1:0]      r_inst_mv;
    logic [MV_W-1:0]      r_filt_mv;

    // history ring and its bookkeeping
    logic [MV_W-1:0]      r_hist [HISTORY_DEPTH];
    logic [MV_W-1:0]      r_oldest;
    logic [HIST_AW-1:0]   r_pos;
    logic [FILL_W-1:0]    r_fill;

    // result buffer
    t_result              r_fifo [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;
    logic [1:0]           r_pend;

    logic [SAMPLE_W-1:0]  sample;
    logic                 completing;
    logic                 in_accept;
    logic                 out_accept;
    logic [SUM_W-1:0]     sum_new;
    logic [SAMPLE_W-1:0]  min_new;
    logic [SAMPLE_W-1:0]  max_new;
    logic [SUM_W-1:0]     trim;
    logic [HIST_AW-1:0]   pos_next;
    logic                 hist_full;
    logic [MV_W:0]        newest_x;
    logic [MV_W:0]        oldest_x;
    t_trend               trend;
    t_result              result;

    assign sample     = i_s_axis_tdata[SAMPLE_W-1:0];
    // the closing sample of a series is known from state alone
    assign completing = (r_discard_left == '0) && (r_count == CNT_W'(SERIES_SAMPLES - 1));
    // closing sample waits only while every buffer slot is spoken for
    assign o_s_axis_tready = !completing || (r_pend != 2'd2);
    assign in_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_accept = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        sum_new = r_sum + SUM_W'(sample);
        min_new = (sample < r_min) ? sample : r_min;
        max_new = (sample > r_max) ? sample : r_max;
        trim    = sum_new - SUM_W'(min_new) - SUM_W'(max_new);
    end

    // configuration port and series accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain           <= GAIN_RESET;
            r_delta          <= DELTA_RESET;
            r_discard_cnt    <= DISCARD_RESET;
            r_discard_left   <= DISCARD_RESET;
            r_count          <= '0;
            r_sum            <= '0;
            r_min            <= '1;
            r_max            <= '0;
            r_scale_in.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VOLTAGE_GAIN:  r_gain        <= i_cfg_data[GAIN_W-1:0];
                    CFG_TREND_DELTA:   r_delta       <= i_cfg_data[DELTA_W-1:0];
                    CFG_DISCARD_COUNT: r_discard_cnt <= i_cfg_data[DISCARD_W-1:0];
                    default: ;
                endcase
            end
            r_scale_in.valid <= in_accept && completing;
            if (in_accept) begin
                if (r_discard_left != '0) begin
                    // settling samples after reset and after each series are dropped
                    r_discard_left <= r_discard_left - 1'b1;
                end else if (completing) begin
                    r_count          <= '0;
                    r_sum            <= '0;
                    r_min            <= '1;
                    r_max            <= '0;
                    r_discard_left   <= r_discard_cnt;
                end else begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= sum_new;
                    r_min   <= min_new;
                    r_max   <= max_new;
                end
            end
        end
        if (in_accept && completing) begin
            r_scale_in.trim <= trim;
        end
    end

    bvc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (r_gain),
        .i_in    (r_scale_in),
        .o_out   (scale_out)
    );

    // q8 to millivolts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= scale_out.valid;
        end
        r_inst_mv <= q8_to_mv(scale_out.inst_q8);
        r_filt_mv <= q8_to_mv(scale_out.filt_q8);
    end

    // entry after the write position is the oldest once the next push lands;
    // its read is registered and the position holds still between series
    assign pos_next = (r_pos == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (r_v6) begin
            r_hist[r_pos] <= r_filt_mv;
        end
        r_oldest <= r_hist[pos_next];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
        end else if (r_v6) begin
            r_pos <= pos_next;
            if (r_fill != FILL_W'(HISTORY_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // trend across the full ring, counting the push of this series
    always_comb begin
        hist_full = (r_fill == FILL_W'(HISTORY_DEPTH)) ||
                    (r_fill == FILL_W'(HISTORY_DEPTH - 1));
        newest_x  = {1'b0, r_filt_mv};
        oldest_x  = {1'b0, r_oldest};
        if (!hist_full) begin
            trend = TREND_UNKNOWN;
        end else if (newest_x > oldest_x + (MV_W+1)'(r_delta)) begin
            trend = TREND_CHARGING;
        end else if (oldest_x > newest_x + (MV_W+1)'(r_delta)) begin
            trend = TREND_DISCHARGING;
        end else begin
            trend = TREND_STABLE;
        end
        result.trend   = trend;
        result.filt_mv = r_filt_mv;
        result.inst_mv = r_inst_mv;
    end

    // result buffer: two words, pending count includes words still in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
            r_pend <= '0;
        end else begin
            if (r_v6) begin
                r_wp <= ~r_wp;
            end
            if (out_accept) begin
                r_rp <= ~r_rp;
            end
            r_cnt  <= r_cnt + {1'b0, r_v6} - {1'b0, out_accept};
            r_pend <= r_pend + {1'b0, in_accept && completing} - {1'b0, out_accept};
        end
        if (r_v6) begin
            r_fifo[r_wp] <= result;
        end
    end

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), r_fifo[r_rp]};

endmodule

`default_nettype wire

[sv/bvc_checker.sv]
// bvc_checker: port-level checks for the battery voltage conditioner
// depends on bvc_pkg; bound to battery_voltage_conditioner_core below
`timescale 1ns / 1ps
`default_nettype none

module bvc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_s_axis_tready,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [bvc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // reset empties the result buffer
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result word offered straight after reset");

    // a fresh series never closes on its first sample, so input is open
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("sample input closed straight after reset");

endmodule

bind battery_voltage_conditioner_core bvc_checker u_bvc_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
// tb_top: self-checking bench for battery_voltage_conditioner_core, sample words in, result words out
// depends on bvc_pkg and the core; a built-in predictor mirrors series, filter and trend state
// with random gaps on both streams, register sweeps between phases and a no-progress watchdog
`timescale 1ns / 1ps

module tb_top;

    import bvc_pkg::*;

    // cycles without any accepted word or register write before the run is declared hung; covers the
    // longest sender gap, the longest sink stall, the pipeline and the idle wait many times over
    localparam int STALL_LIMIT = 2000;
    // settle time after the last result before a register write or the end of the run
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_MAX = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data;
    logic                  m_valid;
    logic                  m_ready;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register mirror
    logic [GAIN_W-1:0]    gain_r;
    logic [DELTA_W-1:0]   delta_r;
    logic [DISCARD_W-1:0] discard_r;

    // predictor state
    logic [DISCARD_W-1:0] skip_left;
    int                   taken;
    int                   acc_sum;
    int                   acc_lo;
    int                   acc_hi;
    logic [Q8_W-1:0]      filt_q8;
    logic [MV_W-1:0]      hist [HISTORY_DEPTH];
    int                   hist_wr;
    int                   hist_cnt;

    t_result pending_results[$];
    int      results_predicted;
    int      kept_samples;
    int      mismatches;
    bit      idle_on;

    battery_voltage_conditioner_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length for either stream: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // q8 millivolts to whole millivolts, half up, clipped to the output range
    function automatic logic [MV_W-1:0] mv_from_q8(input longint unsigned q);
        longint unsigned mv;
        mv = (q + 128) >> 8;
        if (mv > 16383) mv = 16383;
        return mv[MV_W-1:0];
    endfunction

    // one accepted sample: drop it, add it to the series, or close the series
    function automatic void predict_conditioner(input logic [SAMPLE_W-1:0] smp);
        longint unsigned trimmed;
        longint unsigned q;
        longint unsigned fq;
        logic [Q8_W-1:0] inst_q8;
        int              oldest;
        int              newest;
        t_result         r;
        if (skip_left != 0) begin
            skip_left = skip_left - 1'b1;
            return;
        end
        kept_samples++;
        acc_sum += smp;
        if (smp < acc_lo) acc_lo = smp;
        if (smp > acc_hi) acc_hi = smp;
        taken++;
        if (taken < SERIES_SAMPLES) return;

        // trimmed mean times the q16 gain, kept as q8 millivolts
        trimmed = acc_sum - acc_lo - acc_hi;
        q = (trimmed * gain_r + (SERIES_SAMPLES - 2) * 128) / ((SERIES_SAMPLES - 2) * 256);
        inst_q8 = (q > Q8_MAX) ? Q8_MAX : q[Q8_W-1:0];

        // seed a filter that sits below 100 mV, otherwise 0.9 old plus 0.1 new
        if (filt_q8 < SEED_LIMIT_Q8) begin
            filt_q8 = inst_q8;
        end else begin
            fq = filt_q8;
            fq = (fq * 9 + inst_q8 + 5) / 10;
            filt_q8 = (fq > Q8_MAX) ? Q8_MAX : fq[Q8_W-1:0];
        end

        r.inst_mv = mv_from_q8(inst_q8);
        r.filt_mv = mv_from_q8(filt_q8);
        hist[hist_wr] = r.filt_mv;
        hist_wr = (hist_wr + 1) % HISTORY_DEPTH;
        if (hist_cnt < HISTORY_DEPTH) hist_cnt++;

        // newest against oldest entry once the ring has been filled
        if (hist_cnt < HISTORY_DEPTH) begin
            r.trend = TREND_UNKNOWN;
        end else begin
            oldest = hist[hist_wr];
            newest = hist[(hist_wr + HISTORY_DEPTH - 1) % HISTORY_DEPTH];
            if (newest - oldest > int'(delta_r)) r.trend = TREND_CHARGING;
            else if (oldest - newest > int'(delta_r)) r.trend = TREND_DISCHARGING;
            else r.trend = TREND_STABLE;
        end
        pending_results.push_back(r);
        results_predicted++;

        taken     = 0;
        acc_sum   = 0;
        acc_lo    = 4095;
        acc_hi    = 0;
        skip_left = discard_r;
    endfunction

    // every task below starts and ends just after a falling edge

    // one sample word: optional gap, then hold until the core takes it
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= IN_DATA_W'(smp);
        do @(posedge clk); while (!s_ready);
        predict_conditioner(smp);
        @(negedge clk);
    endtask

    // hold the sender until every predicted word is out and the pipeline has settled
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_VOLTAGE_GAIN:  gain_r    = val[GAIN_W-1:0];
            CFG_TREND_DELTA:   delta_r   = val[DELTA_W-1:0];
            CFG_DISCARD_COUNT: discard_r = val[DISCARD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int gain, input int delta, input int discard);
        write_reg(CFG_VOLTAGE_GAIN,  CFG_DATA_W'(gain));
        write_reg(CFG_TREND_DELTA,   CFG_DATA_W'(delta));
        write_reg(CFG_DISCARD_COUNT, CFG_DATA_W'(discard));
    endtask

    // feed words until one series closes; dropped words carry noise, kept ones
    // sit around the level with jitter and the odd rail outlier for the trimming
    task automatic send_series(input int level, input int jitter);
        int start;
        int v;
        start = results_predicted;
        while (results_predicted == start) begin
            if (skip_left != 0) begin
                v = $urandom_range(0, 4095);
            end else if ($urandom_range(0, 15) == 0) begin
                v = $urandom_range(0, 1) ? 4095 : 0;
            end else begin
                v = level - jitter + int'($urandom_range(0, 2 * jitter));
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
            end
            send_sample(v[SAMPLE_W-1:0]);
        end
    endtask

    // rails of the sample field, full and zero gain, first-series seeding
    task automatic test_directed_extremes();
        int first [10] = '{4095, 0, 0, 4095, 1, 4094, 2048, 2047, 'hAAA, 'h555};
        int start;
        idle_on = 1'b0;
        // reset settings: two dropped words, then a series that holds both rails
        foreach (first[i]) send_sample(first[i][SAMPLE_W-1:0]);
        wait_idle();
        write_all(262143, 0, 0);
        // top rail words until the full gain series closes, dropped words included
        start = results_predicted;
        while (results_predicted == start) send_sample(12'hFFF);
        wait_idle();
        // zero gain drags the instant value to nothing, filter decays towards zero
        write_reg(CFG_VOLTAGE_GAIN, '0);
        start = results_predicted;
        while (results_predicted == start) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        wait_idle();
    endtask

    // longest and shortest drop runs, widest and tightest trend window
    task automatic test_discard_extremes();
        idle_on = 1'b1;
        write_all(65536, 1023, 255);
        // the new drop count only applies from the series after next
        repeat (3) send_series($urandom_range(500, 3500), 30);
        wait_idle();
        write_all(131072, 0, 0);
        repeat (3) send_series($urandom_range(500, 3500), 30);
        wait_idle();
    endtask

    // steady ramps up, down and flat long enough to fill the history ring
    task automatic test_trend_ramps(input int kept_target);
        int level;
        int step;
        int r;
        while (kept_samples < kept_target) begin
            idle_on = $urandom_range(0, 3) != 0;
            r = $urandom_range(0, 3);
            write_all(r == 0 ? 131072 : 65536,
                      r == 1 ? 1023 : $urandom_range(0, 120),
                      $urandom_range(0, 3));
            level = $urandom_range(800, 3300);
            step  = int'($urandom_range(0, 80)) - 40;
            repeat (20) begin
                send_series(level, $urandom_range(0, 40));
                level += step;
                if (level < 50 || level > 4000) begin
                    step  = -step;
                    level += 2 * step;
                end
            end
            wait_idle();
        end
    endtask

    // unstructured samples under random register settings
    task automatic test_random_noise(input int kept_target);
        while (kept_samples < kept_target) begin
            idle_on = $urandom_range(0, 3) != 0;
            write_all($urandom_range(0, 5) == 0 ? 0 : $urandom_range(0, 262143),
                      $urandom_range(0, 1023), $urandom_range(0, 5));
            repeat (18) send_series(2048, 2048);
            wait_idle();
        end
    endtask

    // sink side: random back-pressure on the result stream
    initial begin : sink_ready
        int hold;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
            end else begin
                hold = pick_gap();
                m_ready <= (hold == 0);
                if (hold > 0) hold--;
            end
        end
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge clk) begin : check_result
        t_result got;
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            got = t_result'(m_data[RES_W-1:0]);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result word inst %0d filt %0d trend %0d",
                             $time, got.inst_mv, got.filt_mv, got.trend);
            end else begin
                want = pending_results.pop_front();
                if (got.inst_mv !== want.inst_mv || got.filt_mv !== want.filt_mv ||
                    got.trend !== want.trend) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result word mismatch: expected inst %0d filt %0d trend %0d, got inst %0d filt %0d trend %0d",
                                 $time, want.inst_mv, want.filt_mv, want.trend,
                                 got.inst_mv, got.filt_mv, got.trend);
                end
            end
        end
    end

    // hang detection: no word either way and no register write for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_we || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        // every input known from time zero, reset held low
        rst_n    = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_VOLTAGE_GAIN;
        cfg_data = '0;
        idle_on  = 1'b0;

        // predictor starts from the reset values of the core
        gain_r    = GAIN_RESET;
        delta_r   = DELTA_RESET;
        discard_r = DISCARD_RESET;
        skip_left = DISCARD_RESET;
        taken     = 0;
        acc_sum   = 0;
        acc_lo    = 4095;
        acc_hi    = 0;
        filt_q8   = '0;
        hist_wr   = 0;
        hist_cnt  = 0;
        results_predicted = 0;
        kept_samples      = 0;
        mismatches        = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_discard_extremes();
        test_trend_ramps(kept_samples + 300);
        test_random_noise(kept_samples + 250);

        // drain: last results out, then a little extra for stray words
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/bvc_pkg.sv
sv/bvc_scale.sv
sv/battery_voltage_conditioner_core.sv
sv/bvc_checker.sv
sim/tb_top.sv
